// ===== rtl/core/bff_pkg.sv =====
package bff_pkg;

    localparam int LIST_DEPTH = 256;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 112;
    localparam int M_USED_W   = 3 * DATA_W + CNT_W;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_ADD     = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK     = 2'd0,
        STATUS_NO_FIT = 2'd1,
        STATUS_FULL   = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_SIZE = 1'd1;

    localparam logic [DATA_W-1:0] HDR_BYTES = 32'd4;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
    } entry_t;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] user_address;
        logic [DATA_W-1:0] granted_size;
        logic [DATA_W-1:0] free_total;
        logic [CNT_W-1:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic              valid;
        mode_t             mode;
        logic [DATA_W-1:0] address;
        logic [DATA_W-1:0] request_size;
    } request_t;

endpackage

// ===== rtl/core/bff_ram.sv =====
module bff_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/bff_ctrl.sv =====
module bff_ctrl import bff_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  request_t          req,
    output logic              req_ready,
    input  logic [DATA_W-1:0] heap_base,
    input  logic [DATA_W-1:0] heap_size,
    output logic              ram_wr_en,
    output logic [IDX_W-1:0]  ram_wr_addr,
    output entry_t            ram_wr_data,
    output logic              ram_rd_en,
    output logic [IDX_W-1:0]  ram_rd_addr,
    input  entry_t            ram_rd_data,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_CMP,
        ST_A_FIN,
        ST_M_RD,
        ST_M_CMP,
        ST_MOVE,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [DATA_W-1:0] cur_s_reg, cur_s_next;
    logic [DATA_W-1:0] cur_l_reg, cur_l_next;
    logic [DATA_W-1:0] need_reg, need_next;
    logic [IDX_W-1:0]  best_reg, best_next;
    logic [DATA_W-1:0] best_s_reg, best_s_next;
    logic [DATA_W-1:0] best_l_reg, best_l_next;
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  dest_reg, dest_next;
    logic              back_merge_reg, back_merge_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] user_reg, user_next;
    logic [DATA_W-1:0] grant_reg, grant_next;

    logic [CNT_W-1:0]  used_m1;
    logic [CNT_W-1:0]  idx_p1;
    logic [IDX_W-1:0]  idx_a;
    logic [DATA_W:0]   rounded;
    logic [DATA_W+1:0] need_full;
    logic [DATA_W-1:0] cur_end;
    logic [DATA_W-1:0] oth_end;
    logic [DATA_W-1:0] new_start;

    assign used_m1   = used_reg - 1'b1;
    assign idx_p1    = idx_reg + 1'b1;
    assign idx_a     = idx_reg[IDX_W-1:0];
    assign rounded   = ({1'b0, req.request_size} + (DATA_W+1)'(3)) & ~(DATA_W+1)'(3);
    assign need_full = {1'b0, rounded} + (DATA_W+2)'(HDR_BYTES);
    assign cur_end   = cur_s_reg + cur_l_reg;
    assign oth_end   = ram_rd_data.start + ram_rd_data.length;
    assign new_start = (req.mode == MODE_FREE) ? req.address - HDR_BYTES : req.address;

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res.status       = status_reg;
    assign res.user_address = user_reg;
    assign res.granted_size = grant_reg;
    assign res.free_total   = sum_reg;
    assign res.entry_count  = used_reg;

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        sum_next        = sum_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        cur_s_next      = cur_s_reg;
        cur_l_next      = cur_l_reg;
        need_next       = need_reg;
        best_next       = best_reg;
        best_s_next     = best_s_reg;
        best_l_next     = best_l_reg;
        found_next      = found_reg;
        dest_next       = dest_reg;
        back_merge_next = back_merge_reg;
        status_next     = status_reg;
        user_next       = user_reg;
        grant_next      = grant_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = '0;
        ram_wr_data     = '0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;

        case (state_reg)
            ST_IDLE: begin
                if (req.valid) begin
                    status_next = STATUS_OK;
                    user_next   = '0;
                    grant_next  = '0;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    state_next  = ST_DONE;
                    case (req.mode)
                        MODE_ALLOC: begin
                            need_next = need_full[DATA_W-1:0];
                            if (need_full[DATA_W+1:DATA_W] != 2'd0 || used_reg == '0) begin
                                status_next = STATUS_NO_FIT;
                            end else begin
                                state_next = ST_A_RD;
                            end
                        end
                        MODE_FREE, MODE_ADD: begin
                            if (used_reg == CNT_W'(LIST_DEPTH)) begin
                                status_next = STATUS_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = used_reg[IDX_W-1:0];
                                ram_wr_data = '{start: new_start, length: req.request_size};
                                cur_next    = used_reg[IDX_W-1:0];
                                cur_s_next  = new_start;
                                cur_l_next  = req.request_size;
                                used_next   = used_reg + 1'b1;
                                sum_next    = sum_reg + req.request_size;
                                if (req.mode == MODE_FREE) begin
                                    state_next = ST_M_RD;
                                end
                            end
                        end
                        default: begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = '0;
                            ram_wr_data = '{start: heap_base, length: heap_size};
                            used_next   = CNT_W'(1);
                            sum_next    = heap_size;
                        end
                    endcase
                end
            end
            ST_A_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = idx_a;
                state_next  = ST_A_CMP;
            end
            ST_A_CMP: begin
                if (ram_rd_data.length >= need_reg &&
                    (!found_reg || ram_rd_data.length < best_l_reg)) begin
                    found_next  = 1'b1;
                    best_next   = idx_a;
                    best_s_next = ram_rd_data.start;
                    best_l_next = ram_rd_data.length;
                end
                idx_next   = idx_p1;
                state_next = (idx_p1 == used_reg) ? ST_A_FIN : ST_A_RD;
            end
            ST_A_FIN: begin
                state_next = ST_DONE;
                if (!found_reg) begin
                    status_next = STATUS_NO_FIT;
                end else begin
                    user_next  = best_s_reg + HDR_BYTES;
                    grant_next = need_reg;
                    sum_next   = sum_reg - need_reg;
                    if (best_l_reg == need_reg) begin
                        // exact fit: swap the last entry into the hole
                        used_next = used_m1;
                        if (best_reg != used_m1[IDX_W-1:0]) begin
                            ram_rd_en       = 1'b1;
                            ram_rd_addr     = used_m1[IDX_W-1:0];
                            dest_next       = best_reg;
                            back_merge_next = 1'b0;
                            state_next      = ST_MOVE;
                        end
                    end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = best_reg;
                        ram_wr_data = '{start: best_s_reg + need_reg,
                                        length: best_l_reg - need_reg};
                    end
                end
            end
            ST_M_RD: begin
                if (idx_reg == used_reg) begin
                    state_next = ST_DONE;
                end else if (idx_a == cur_reg) begin
                    idx_next = idx_p1;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_a;
                    state_next  = ST_M_CMP;
                end
            end
            ST_M_CMP: begin
                idx_next   = idx_p1;
                state_next = ST_M_RD;
                if (cur_end == ram_rd_data.start) begin
                    // absorb the entry that starts at our end
                    cur_l_next = cur_l_reg + ram_rd_data.length;
                    used_next  = used_m1;
                    idx_next   = '0;
                    ram_wr_en  = 1'b1;
                    ram_wr_data = '{start: cur_s_reg, length: cur_l_reg + ram_rd_data.length};
                    if (cur_reg == used_m1[IDX_W-1:0]) begin
                        ram_wr_addr = idx_a;
                        cur_next    = idx_a;
                    end else begin
                        ram_wr_addr = cur_reg;
                        if (idx_a != used_m1[IDX_W-1:0]) begin
                            ram_rd_en       = 1'b1;
                            ram_rd_addr     = used_m1[IDX_W-1:0];
                            dest_next       = idx_a;
                            back_merge_next = 1'b1;
                            state_next      = ST_MOVE;
                        end
                    end
                end else if (cur_s_reg == oth_end) begin
                    // extend the entry that ends at our start
                    cur_s_next  = ram_rd_data.start;
                    cur_l_next  = ram_rd_data.length + cur_l_reg;
                    used_next   = used_m1;
                    idx_next    = '0;
                    ram_wr_en   = 1'b1;
                    ram_wr_data = '{start: ram_rd_data.start,
                                    length: ram_rd_data.length + cur_l_reg};
                    if (idx_a == used_m1[IDX_W-1:0]) begin
                        ram_wr_addr = cur_reg;
                    end else begin
                        ram_wr_addr = idx_a;
                        cur_next    = idx_a;
                        if (cur_reg != used_m1[IDX_W-1:0]) begin
                            ram_rd_en       = 1'b1;
                            ram_rd_addr     = used_m1[IDX_W-1:0];
                            dest_next       = cur_reg;
                            back_merge_next = 1'b1;
                            state_next      = ST_MOVE;
                        end
                    end
                end
            end
            ST_MOVE: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = dest_reg;
                ram_wr_data = ram_rd_data;
                idx_next    = '0;
                state_next  = back_merge_reg ? ST_M_RD : ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            sum_reg   <= '0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            sum_reg   <= sum_next;
        end
        idx_reg        <= idx_next;
        cur_reg        <= cur_next;
        cur_s_reg      <= cur_s_next;
        cur_l_reg      <= cur_l_next;
        need_reg       <= need_next;
        best_reg       <= best_next;
        best_s_reg     <= best_s_next;
        best_l_reg     <= best_l_next;
        found_reg      <= found_next;
        dest_reg       <= dest_next;
        back_merge_reg <= back_merge_next;
        status_reg     <= status_next;
        user_reg       <= user_next;
        grant_reg      <= grant_next;
    end

endmodule

// ===== rtl/core/best_fit_free_list_allocator.sv =====
// Best-fit free-list allocator.
// Input channel s_*: one transfer per operation; s_tuser carries the mode
// (alloc, free, add block, restart), s_tdata the address and size.
// Output channel m_*: exactly one result transfer per operation, with the
// status in m_tuser and user address, granted size, free total and entry
// count in m_tdata.
// Restart and add block finish without a scan. Alloc scans every entry,
// through a read state and a compare state for each. Free rescans the
// list after every merge, with a read and a compare state per entry
// visited, plus a move state per swap. The scans are sequential since
// the region memory has a single read port.
// One operation is in flight at a time; s_tready is high while the
// sequencer is idle, also while a finished result waits in the output
// register. If the receiver stalls, the next finished result holds in the
// sequencer until the output register frees up.
// Reset empties the list and clears the free total; the region memory is
// not cleared since only entries below the count are ever read.
// heap_base and heap_size may be written at any time the block is idle.
module best_fit_free_list_allocator import bff_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // address, request_size
    input  logic [1:0]           s_tuser,   // mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // user_address, granted_size, free_total, entry_count
    output logic [1:0]           m_tuser    // status
);

    logic [DATA_W-1:0] heap_base_reg;
    logic [DATA_W-1:0] heap_size_reg;
    logic              m_valid_reg;
    result_t           m_res_reg;

    request_t          req;
    logic              req_ready;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    entry_t            ram_wr_data;
    logic              ram_rd_en;
    logic [IDX_W-1:0]  ram_rd_addr;
    entry_t            ram_rd_data;
    logic              res_valid;
    logic              res_ready;
    result_t           res;

    assign req.valid        = s_tvalid;
    assign req.mode         = mode_t'(s_tuser);
    assign req.address      = s_tdata[DATA_W-1:0];
    assign req.request_size = s_tdata[2*DATA_W-1:DATA_W];
    assign s_tready         = req_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            heap_size_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_HEAP_BASE: heap_base_reg <= cfg_wdata;
                CFG_HEAP_SIZE: heap_size_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bff_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(LIST_DEPTH)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    bff_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (req),
        .req_ready  (req_ready),
        .heap_base  (heap_base_reg),
        .heap_size  (heap_size_reg),
        .ram_wr_en  (ram_wr_en),
        .ram_wr_addr(ram_wr_addr),
        .ram_wr_data(ram_wr_data),
        .ram_rd_en  (ram_rd_en),
        .ram_rd_addr(ram_rd_addr),
        .ram_rd_data(ram_rd_data),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), m_res_reg.entry_count,
                       m_res_reg.free_total, m_res_reg.granted_size,
                       m_res_reg.user_address};

endmodule

// ===== rtl/core/bff_checker.sv =====
module bff_checker import bff_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_addr,
    input logic [DATA_W-1:0]    cfg_wdata,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic [1:0]           s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [1:0]           m_tuser
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3*DATA_W +: CNT_W] <= CNT_W'(LIST_DEPTH))
        else $error("entry count beyond list depth");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STATUS_OK |->
            m_tdata[DATA_W-1:0] == '0 && m_tdata[2*DATA_W-1:DATA_W] == '0)
        else $error("failed operation reports an address or size");

    a_grant_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[DATA_W+1:DATA_W] == 2'd0)
        else $error("granted size not a multiple of four");

endmodule

bind best_fit_free_list_allocator bff_checker u_bff_checker (.*);
